// ===== rtl/core/rcap_pkg.sv =====
// Package for the reference-counted address pool: word types, codes and the
// command and status structs between controller and datapath.
// Depends on nothing.
package rcap_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned PortW    = 16;
  localparam int unsigned RefsW    = 16;
  localparam int unsigned HandleW  = 5;
  localparam int unsigned TotalW   = 6;
  localparam int unsigned LimitW   = 6;
  localparam int unsigned ListMax  = 32;
  localparam int unsigned ListCntW = $clog2(ListMax);

  localparam logic [LimitW-1:0] LimitReset = 6'd32;
  localparam logic [RefsW-1:0]  RefsMax    = 16'hFFFF;

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_FIND    = 3'd1,
    FN_REMOVE  = 3'd2,
    FN_RELEASE = 3'd3,
    FN_LIST    = 3'd4,
    FN_CLEAR   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK_NEW    = 2'd0,
    STAT_OK_EXIST  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_CHK,
    S_ADD_NEW,
    S_ADD_TAKE,
    S_UNLINK_A,
    S_UNLINK_B,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [AddrW-1:0]   address;
    logic [PortW-1:0]   port;
    logic [HandleW-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [HandleW-1:0] entry_index;
    logic [AddrW-1:0]   entry_address;
    logic [PortW-1:0]   entry_port;
    logic [RefsW-1:0]   ref_count;
    logic [TotalW-1:0]  active_total;
    logic               last;
  } out_t;

  typedef struct packed {
    logic    load_in;
    logic    walk_init;
    logic    rd_cur;
    logic    advance;
    logic    cap;
    logic    upd_add;
    logic    upd_rel;
    logic    rd_free;
    logic    add_take;
    logic    unlink_a;
    logic    unlink_b;
    logic    clear;
    logic    st_load;
    status_e st_code;
    logic    st_entry;
    logic    emit;
    logic    emit_list;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  handle_ok;
    logic  head_null;
    logic  cur_null;
    logic  addr_hit;
    logic  idx_hit;
    logic  next_null;
    logic  rel_zero;
    logic  full;
    logic  out_free;
    logic  list_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/rcap_ctrl.sv =====
// Controller of the address pool: the state machine that sequences list walks,
// entry updates, unlinking and the output word. Depends on rcap_pkg.
module rcap_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  rcap_pkg::dp_stat_t   stat_i,
  output rcap_pkg::ctrl_cmd_t  cmd_o,
  output logic                 idle_o
);

  rcap_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcap_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcap_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rcap_pkg::S_DISPATCH;
      end
      rcap_pkg::S_DISPATCH: begin
        unique case (stat_i.func) inside
          rcap_pkg::FN_ADD, rcap_pkg::FN_FIND: state_d = rcap_pkg::S_WALK_RD;
          rcap_pkg::FN_REMOVE, rcap_pkg::FN_RELEASE: begin
            state_d = stat_i.handle_ok ? rcap_pkg::S_WALK_RD : rcap_pkg::S_EMIT;
          end
          rcap_pkg::FN_LIST: begin
            state_d = stat_i.head_null ? rcap_pkg::S_EMIT : rcap_pkg::S_WALK_RD;
          end
          default: state_d = rcap_pkg::S_EMIT;
        endcase
      end
      rcap_pkg::S_WALK_RD: begin
        if (!stat_i.cur_null) begin
          state_d = rcap_pkg::S_WALK_CHK;
        end else if (stat_i.func == rcap_pkg::FN_ADD) begin
          state_d = rcap_pkg::S_ADD_NEW;
        end else begin
          state_d = rcap_pkg::S_EMIT;
        end
      end
      rcap_pkg::S_WALK_CHK: begin
        unique case (stat_i.func)
          rcap_pkg::FN_ADD: begin
            if (stat_i.addr_hit) state_d = rcap_pkg::S_EMIT;
            else if (stat_i.next_null) state_d = rcap_pkg::S_ADD_NEW;
          end
          rcap_pkg::FN_FIND: begin
            if (stat_i.addr_hit || stat_i.next_null) state_d = rcap_pkg::S_EMIT;
          end
          rcap_pkg::FN_REMOVE: begin
            if (stat_i.idx_hit) state_d = rcap_pkg::S_UNLINK_A;
            else if (stat_i.next_null) state_d = rcap_pkg::S_EMIT;
          end
          rcap_pkg::FN_RELEASE: begin
            if (stat_i.idx_hit) begin
              state_d = stat_i.rel_zero ? rcap_pkg::S_UNLINK_A : rcap_pkg::S_EMIT;
            end else if (stat_i.next_null) begin
              state_d = rcap_pkg::S_EMIT;
            end
          end
          rcap_pkg::FN_LIST: begin
            if (stat_i.out_free && (stat_i.list_last || stat_i.next_null)) begin
              state_d = rcap_pkg::S_IDLE;
            end
          end
          default: state_d = rcap_pkg::S_IDLE;
        endcase
      end
      rcap_pkg::S_ADD_NEW: begin
        state_d = stat_i.full ? rcap_pkg::S_EMIT : rcap_pkg::S_ADD_TAKE;
      end
      rcap_pkg::S_ADD_TAKE: state_d = rcap_pkg::S_EMIT;
      rcap_pkg::S_UNLINK_A: state_d = rcap_pkg::S_UNLINK_B;
      rcap_pkg::S_UNLINK_B: state_d = rcap_pkg::S_EMIT;
      rcap_pkg::S_EMIT: begin
        if (stat_i.out_free) state_d = rcap_pkg::S_IDLE;
      end
      default: state_d = rcap_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.st_code = rcap_pkg::STAT_OK_NEW;
    idle_o        = 1'b0;
    unique case (state_q)
      rcap_pkg::S_IDLE: begin
        idle_o        = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      rcap_pkg::S_DISPATCH: begin
        unique case (stat_i.func) inside
          rcap_pkg::FN_ADD, rcap_pkg::FN_FIND: cmd_o.walk_init = 1'b1;
          rcap_pkg::FN_REMOVE, rcap_pkg::FN_RELEASE: begin
            if (stat_i.handle_ok) begin
              cmd_o.walk_init = 1'b1;
            end else begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = rcap_pkg::STAT_NOT_FOUND;
            end
          end
          rcap_pkg::FN_LIST: begin
            if (stat_i.head_null) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = rcap_pkg::STAT_NOT_FOUND;
            end else begin
              cmd_o.walk_init = 1'b1;
            end
          end
          rcap_pkg::FN_CLEAR: begin
            cmd_o.clear   = 1'b1;
            cmd_o.st_load = 1'b1;
            cmd_o.st_code = rcap_pkg::STAT_OK_NEW;
          end
          default: begin
            cmd_o.st_load = 1'b1;
            cmd_o.st_code = rcap_pkg::STAT_NOT_FOUND;
          end
        endcase
      end
      rcap_pkg::S_WALK_RD: begin
        if (!stat_i.cur_null) begin
          cmd_o.rd_cur = 1'b1;
        end else if (stat_i.func != rcap_pkg::FN_ADD) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = rcap_pkg::STAT_NOT_FOUND;
        end
      end
      rcap_pkg::S_WALK_CHK: begin
        unique case (stat_i.func) inside
          rcap_pkg::FN_ADD: begin
            if (stat_i.addr_hit) begin
              cmd_o.upd_add  = 1'b1;
              cmd_o.st_load  = 1'b1;
              cmd_o.st_code  = rcap_pkg::STAT_OK_EXIST;
              cmd_o.st_entry = 1'b1;
            end else if (!stat_i.next_null) begin
              cmd_o.advance = 1'b1;
            end
          end
          rcap_pkg::FN_FIND: begin
            if (stat_i.addr_hit) begin
              cmd_o.cap      = 1'b1;
              cmd_o.st_load  = 1'b1;
              cmd_o.st_code  = rcap_pkg::STAT_OK_EXIST;
              cmd_o.st_entry = 1'b1;
            end else if (stat_i.next_null) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = rcap_pkg::STAT_NOT_FOUND;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          rcap_pkg::FN_REMOVE, rcap_pkg::FN_RELEASE: begin
            if (stat_i.idx_hit) begin
              cmd_o.cap      = (stat_i.func == rcap_pkg::FN_REMOVE);
              cmd_o.upd_rel  = (stat_i.func == rcap_pkg::FN_RELEASE);
              cmd_o.st_load  = 1'b1;
              cmd_o.st_code  = rcap_pkg::STAT_OK_NEW;
              cmd_o.st_entry = 1'b1;
            end else if (stat_i.next_null) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = rcap_pkg::STAT_NOT_FOUND;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          rcap_pkg::FN_LIST: begin
            if (stat_i.out_free) begin
              cmd_o.emit_list = 1'b1;
              cmd_o.advance   = !(stat_i.list_last || stat_i.next_null);
            end
          end
          default: ;
        endcase
      end
      rcap_pkg::S_ADD_NEW: begin
        if (stat_i.full) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = rcap_pkg::STAT_FULL;
        end else begin
          cmd_o.rd_free = 1'b1;
        end
      end
      rcap_pkg::S_ADD_TAKE: begin
        cmd_o.add_take = 1'b1;
        cmd_o.st_load  = 1'b1;
        cmd_o.st_code  = rcap_pkg::STAT_OK_NEW;
        cmd_o.st_entry = 1'b1;
      end
      rcap_pkg::S_UNLINK_A: cmd_o.unlink_a = 1'b1;
      rcap_pkg::S_UNLINK_B: cmd_o.unlink_b = 1'b1;
      rcap_pkg::S_EMIT: cmd_o.emit = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/rcap_dpath.sv =====
// Datapath of the address pool: entry memories, link memory with valid bits,
// list heads, counters, captured entry and the output register. Depends on rcap_pkg.
module rcap_dpath #(
  parameter int unsigned POOL_SIZE = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rcap_pkg::ctrl_cmd_t                   cmd_i,
  output rcap_pkg::dp_stat_t                    stat_o,
  input  rcap_pkg::in_t                         in_data_i,
  input  logic                                  cfg_we_i,
  input  logic [rcap_pkg::LimitW-1:0]           cfg_wdata_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output rcap_pkg::out_t                        out_data_o
);

  localparam int unsigned IdxW  = $clog2(POOL_SIZE);
  localparam int unsigned LinkW = $clog2(POOL_SIZE + 1);
  localparam int unsigned AW    = rcap_pkg::AddrW;
  localparam int unsigned PW    = rcap_pkg::PortW;
  localparam int unsigned RW    = rcap_pkg::RefsW;
  localparam int unsigned HW    = rcap_pkg::HandleW;
  localparam int unsigned TW    = rcap_pkg::TotalW;
  localparam int unsigned LW    = rcap_pkg::LimitW;
  localparam int unsigned CntW  = rcap_pkg::ListCntW;
  localparam logic [LinkW-1:0] NullLink = LinkW'(POOL_SIZE);
  localparam logic [CntW-1:0]  CntLast  = CntW'(rcap_pkg::ListMax - 1);

  // Input word and configuration.
  rcap_pkg::func_e   func_q;
  logic [AW-1:0]     addr_q;
  logic [PW-1:0]     port_q;
  logic [HW-1:0]     hnd_q;
  logic [LW-1:0]     limit_q;

  // List state.
  logic [LinkW-1:0]  head_q, free_q, count_q;
  logic [LinkW-1:0]  cur_q, prev_q, nxt_q;
  logic [POOL_SIZE-1:0] link_vld_q;
  logic [CntW-1:0]   lst_cnt_q;

  // Captured entry and pending result.
  logic [IdxW-1:0]   ent_idx_q;
  logic [AW-1:0]     ent_addr_q;
  logic [PW-1:0]     ent_port_q;
  logic [RW-1:0]     ent_refs_q;
  rcap_pkg::status_e res_status_q;
  logic              res_entry_q;

  // Memories and their registered read data.
  logic [AW-1:0]     addr_mem [POOL_SIZE];
  logic [PW-1:0]     port_mem [POOL_SIZE];
  logic [RW-1:0]     refs_mem [POOL_SIZE];
  logic [LinkW-1:0]  link_mem [POOL_SIZE];
  logic [IdxW-1:0]   rd_idx_q;
  logic [AW-1:0]     addr_rd_q;
  logic [PW-1:0]     port_rd_q;
  logic [RW-1:0]     refs_rd_q;
  logic [LinkW-1:0]  link_rd_q;
  logic              vld_rd_q;

  logic              out_valid_q;
  rcap_pkg::out_t    out_q, out_d;

  logic [LinkW-1:0]  link_eff, rd_sel, lw_d;
  logic [IdxW-1:0]   rd_a, lw_a;
  logic              rd_en, dw_en, lw_en, prev_null, out_free;
  logic [AW-1:0]     dw_addr;
  logic [PW-1:0]     dw_port;
  logic [RW-1:0]     dw_refs, refs_inc, refs_dec;

  // A link never written reads as the next entry, giving the initial free chain.
  assign link_eff  = vld_rd_q ? link_rd_q : (LinkW'(rd_idx_q) + LinkW'(1));
  assign prev_null = (prev_q == NullLink);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign refs_inc  = (refs_rd_q == rcap_pkg::RefsMax) ? refs_rd_q : refs_rd_q + RW'(1);
  assign refs_dec  = (refs_rd_q != '0) ? refs_rd_q - RW'(1) : '0;

  always_comb begin
    rd_en = cmd_i.rd_cur || cmd_i.advance || cmd_i.rd_free;
    if (cmd_i.rd_free) begin
      rd_sel = free_q;
    end else if (cmd_i.advance) begin
      rd_sel = link_eff;
    end else begin
      rd_sel = cur_q;
    end
    rd_a = rd_sel[IdxW-1:0];
  end

  always_comb begin
    dw_en = cmd_i.upd_add || cmd_i.upd_rel || cmd_i.add_take;
    if (cmd_i.add_take) begin
      dw_addr = addr_q;
      dw_port = port_q;
      dw_refs = RW'(1);
    end else if (cmd_i.upd_add) begin
      dw_addr = addr_rd_q;
      dw_port = port_q;
      dw_refs = refs_inc;
    end else begin
      dw_addr = addr_rd_q;
      dw_port = port_rd_q;
      dw_refs = refs_dec;
    end
  end

  always_comb begin
    lw_en = (cmd_i.unlink_a && !prev_null) || cmd_i.unlink_b || cmd_i.add_take;
    if (cmd_i.unlink_a) begin
      lw_a = prev_q[IdxW-1:0];
      lw_d = nxt_q;
    end else if (cmd_i.unlink_b) begin
      lw_a = cur_q[IdxW-1:0];
      lw_d = free_q;
    end else begin
      lw_a = rd_idx_q;
      lw_d = head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dw_en) begin
      addr_mem[rd_idx_q] <= dw_addr;
      port_mem[rd_idx_q] <= dw_port;
      refs_mem[rd_idx_q] <= dw_refs;
    end
    if (lw_en) begin
      link_mem[lw_a] <= lw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q  <= rd_a;
      addr_rd_q <= addr_mem[rd_a];
      port_rd_q <= port_mem[rd_a];
      refs_rd_q <= refs_mem[rd_a];
      link_rd_q <= link_mem[rd_a];
      vld_rd_q  <= link_vld_q[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= rcap_pkg::LimitReset;
      head_q      <= NullLink;
      free_q      <= '0;
      count_q     <= '0;
      link_vld_q  <= '0;
      lst_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        head_q     <= NullLink;
        free_q     <= '0;
        count_q    <= '0;
        link_vld_q <= '0;
      end else begin
        if (lw_en) begin
          link_vld_q[lw_a] <= 1'b1;
        end
        if (cmd_i.add_take) begin
          free_q  <= link_eff;
          head_q  <= LinkW'(rd_idx_q);
          count_q <= count_q + LinkW'(1);
        end
        if (cmd_i.unlink_a && prev_null) begin
          head_q <= nxt_q;
        end
        if (cmd_i.unlink_b) begin
          free_q <= cur_q;
          if (count_q != '0) begin
            count_q <= count_q - LinkW'(1);
          end
        end
      end
      if (cmd_i.walk_init) begin
        lst_cnt_q <= '0;
      end else if (cmd_i.emit_list) begin
        lst_cnt_q <= lst_cnt_q + CntW'(1);
      end
      if (cmd_i.emit || cmd_i.emit_list) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= rcap_pkg::func_e'(in_data_i.func);
      addr_q <= in_data_i.address;
      port_q <= in_data_i.port;
      hnd_q  <= in_data_i.handle;
    end
    if (cmd_i.walk_init) begin
      cur_q  <= head_q;
      prev_q <= NullLink;
    end else if (cmd_i.advance) begin
      cur_q  <= link_eff;
      prev_q <= cur_q;
    end
    if (cmd_i.cap || dw_en) begin
      ent_idx_q <= rd_idx_q;
      nxt_q     <= link_eff;
      if (cmd_i.cap) begin
        ent_addr_q <= addr_rd_q;
        ent_port_q <= port_rd_q;
        ent_refs_q <= refs_rd_q;
      end else begin
        ent_addr_q <= dw_addr;
        ent_port_q <= dw_port;
        ent_refs_q <= dw_refs;
      end
    end
    if (cmd_i.st_load) begin
      res_status_q <= cmd_i.st_code;
      res_entry_q  <= cmd_i.st_entry;
    end
    if (cmd_i.emit || cmd_i.emit_list) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d              = '0;
    out_d.active_total = TW'(count_q);
    if (cmd_i.emit_list) begin
      out_d.status        = rcap_pkg::STAT_OK_NEW;
      out_d.entry_index   = HW'(rd_idx_q);
      out_d.entry_address = addr_rd_q;
      out_d.entry_port    = port_rd_q;
      out_d.ref_count     = refs_rd_q;
      out_d.last          = (lst_cnt_q == CntLast) || (link_eff >= NullLink);
    end else begin
      out_d.status = res_status_q;
      out_d.last   = 1'b1;
      if (res_entry_q) begin
        out_d.entry_index   = HW'(ent_idx_q);
        out_d.entry_address = ent_addr_q;
        out_d.entry_port    = ent_port_q;
        out_d.ref_count     = ent_refs_q;
      end
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.func      = func_q;
    stat_o.handle_ok = (32'(hnd_q) < POOL_SIZE);
    stat_o.head_null = (head_q >= NullLink);
    stat_o.cur_null  = (cur_q >= NullLink);
    stat_o.addr_hit  = (addr_rd_q == addr_q);
    stat_o.idx_hit   = (cur_q == LinkW'(hnd_q));
    stat_o.next_null = (link_eff >= NullLink);
    stat_o.rel_zero  = (refs_rd_q <= RW'(1));
    stat_o.full      = (32'(count_q) >= 32'(limit_q)) || (free_q >= NullLink);
    stat_o.out_free  = out_free;
    stat_o.list_last = (lst_cnt_q == CntLast);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/refcounted_address_pool.sv =====
// Top level of the reference-counted address pool: controller, datapath and checks.
// Depends on rcap_pkg, rcap_ctrl and rcap_dpath.
//
// The pool takes one command word at a time and answers with one result word,
// or one word per active entry for a list (one not-found word if none is active).
// A command walks the newest-first chain one active entry at a time; a remove,
// or a release that drops the last reference, then unlinks the entry. A list
// delivers one word per cycle while the output is not stalled. The walk rate is
// set by the link memory, whose registered read data addresses the next read.
// A new command is taken as soon as the previous result sits in the output
// register; no clearing pass is needed after reset.
module refcounted_address_pool #(
  parameter int unsigned POOL_SIZE = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rcap_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rcap_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic [rcap_pkg::LimitW-1:0]  cfg_wdata_i
);

  rcap_pkg::ctrl_cmd_t cmd;
  rcap_pkg::dp_stat_t  stat;
  logic                idle;

  rcap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  rcap_dpath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !idle;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("pool took a second word straight after the first");

  a_empty_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == rcap_pkg::STAT_FULL ||
                    out_data_o.status == rcap_pkg::STAT_NOT_FOUND)
    |-> out_data_o.entry_index == '0 && out_data_o.entry_address == '0 &&
        out_data_o.entry_port == '0 && out_data_o.ref_count == '0)
    else $error("failed result carries entry fields");

  a_only_list_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.status == rcap_pkg::STAT_OK_NEW)
    else $error("non-final result word with a status other than ok");

  a_existing_has_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == rcap_pkg::STAT_OK_EXIST
    |-> out_data_o.ref_count != '0)
    else $error("existing entry reported with zero references");

endmodule

// ===== bench/tb_refcounted_address_pool.sv =====
// Self-checking bench for refcounted_address_pool: command words drive a bit-exact pool
// model; each result word is compared field by field with the word that model owes
// or a typed plan row fixes. Depends on rcap_pkg and the refcounted_address_pool RTL.
module tb_refcounted_address_pool;

  localparam int unsigned Pool       = 32;
  localparam logic [5:0]  NoLink     = 6'd32;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned RepAdds    = 6;
  localparam int unsigned MixCount   = 33;

  typedef struct packed {
    logic            cfg;
    logic [5:0]      limit;
    rcap_pkg::func_e op;
    logic [31:0]     addr;
    logic [15:0]     port;
    logic [4:0]      handle;
    logic            typed;
    rcap_pkg::out_t  want;
  } row_t;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  rcap_pkg::in_t               in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  rcap_pkg::out_t              out_data;
  logic                        cfg_we    = 1'b0;
  logic [rcap_pkg::LimitW-1:0] cfg_wdata = rcap_pkg::LimitReset;

  logic [31:0] slot_addr [Pool];
  logic [15:0] slot_port [Pool];
  logic [15:0] slot_refs [Pool];
  logic [5:0]  slot_next [Pool];
  logic [5:0]  free_top;
  logic [5:0]  live_head;
  logic [5:0]  live_count;
  logic [5:0]  limit_reg;

  rcap_pkg::out_t owed [$];
  rcap_pkg::out_t step_out [$];
  logic [31:0]    addr_set [48];
  row_t           plan [20];

  int failures       = 0;
  int words_sent     = 0;
  int words_checked  = 0;
  int full_seen      = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 12;
  int recv_stall_pct = 77;

  refcounted_address_pool #(
    .POOL_SIZE(Pool)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void rebuild_pool();
    for (int i = 0; i < Pool; i++) begin
      slot_next[i] = 6'(i + 1);
    end
    free_top   = 6'd0;
    live_head  = NoLink;
    live_count = 6'd0;
  endfunction

  function automatic rcap_pkg::out_t result_word(rcap_pkg::status_e st, logic [5:0] idx,
                                                 logic has_entry, logic fin);
    rcap_pkg::out_t r;
    r = '0;
    r.status = st;
    if (has_entry) begin
      r.entry_index   = idx[4:0];
      r.entry_address = slot_addr[idx];
      r.entry_port    = slot_port[idx];
      r.ref_count     = slot_refs[idx];
    end
    r.active_total = live_count;
    r.last         = fin;
    return r;
  endfunction

  function automatic logic [5:0] locate(logic [31:0] a);
    logic [5:0] p;
    p = live_head;
    for (int n = 0; n < Pool && p != NoLink; n++) begin
      if (slot_addr[p] == a) return p;
      p = slot_next[p];
    end
    return NoLink;
  endfunction

  function automatic logic holds(logic [5:0] h);
    logic [5:0] p;
    p = live_head;
    for (int n = 0; n < Pool && p != NoLink; n++) begin
      if (p == h) return 1'b1;
      p = slot_next[p];
    end
    return 1'b0;
  endfunction

  function automatic logic detach(logic [5:0] h);
    logic [5:0] prev;
    logic [5:0] p;
    prev = NoLink;
    p    = live_head;
    for (int n = 0; n < Pool && p != NoLink; n++) begin
      if (p == h) begin
        if (prev == NoLink) begin
          live_head = slot_next[p];
        end else begin
          slot_next[prev] = slot_next[p];
        end
        slot_next[p] = free_top;
        free_top     = p;
        if (live_count != 0) live_count--;
        return 1'b1;
      end
      prev = p;
      p    = slot_next[p];
    end
    return 1'b0;
  endfunction

  // Applies one command word to the pool and leaves its result words in step_out.
  function automatic void pool_step(rcap_pkg::in_t w);
    logic [5:0] e;
    logic [5:0] p;
    logic [5:0] nx;
    logic [5:0] h;
    int         k;
    step_out.delete();
    h = {1'b0, w.handle};
    case (rcap_pkg::func_e'(w.func))
      rcap_pkg::FN_ADD: begin
        e = locate(w.address);
        if (e != NoLink) begin
          slot_port[e] = w.port;
          if (slot_refs[e] != rcap_pkg::RefsMax) slot_refs[e]++;
          step_out.push_back(result_word(rcap_pkg::STAT_OK_EXIST, e, 1'b1, 1'b1));
        end else if (live_count >= limit_reg || free_top == NoLink) begin
          step_out.push_back(result_word(rcap_pkg::STAT_FULL, 6'd0, 1'b0, 1'b1));
        end else begin
          e            = free_top;
          free_top     = slot_next[e];
          slot_next[e] = live_head;
          live_head    = e;
          live_count++;
          slot_addr[e] = w.address;
          slot_port[e] = w.port;
          slot_refs[e] = 16'd1;
          step_out.push_back(result_word(rcap_pkg::STAT_OK_NEW, e, 1'b1, 1'b1));
        end
      end
      rcap_pkg::FN_FIND: begin
        e = locate(w.address);
        if (e != NoLink) begin
          step_out.push_back(result_word(rcap_pkg::STAT_OK_EXIST, e, 1'b1, 1'b1));
        end else begin
          step_out.push_back(result_word(rcap_pkg::STAT_NOT_FOUND, 6'd0, 1'b0, 1'b1));
        end
      end
      rcap_pkg::FN_REMOVE: begin
        if (detach(h)) begin
          step_out.push_back(result_word(rcap_pkg::STAT_OK_NEW, h, 1'b1, 1'b1));
        end else begin
          step_out.push_back(result_word(rcap_pkg::STAT_NOT_FOUND, 6'd0, 1'b0, 1'b1));
        end
      end
      rcap_pkg::FN_RELEASE: begin
        if (holds(h)) begin
          if (slot_refs[h] != 16'd0) slot_refs[h]--;
          if (slot_refs[h] == 16'd0) void'(detach(h));
          step_out.push_back(result_word(rcap_pkg::STAT_OK_NEW, h, 1'b1, 1'b1));
        end else begin
          step_out.push_back(result_word(rcap_pkg::STAT_NOT_FOUND, 6'd0, 1'b0, 1'b1));
        end
      end
      rcap_pkg::FN_LIST: begin
        p = live_head;
        k = 0;
        if (p == NoLink) begin
          step_out.push_back(result_word(rcap_pkg::STAT_NOT_FOUND, 6'd0, 1'b0, 1'b1));
        end else begin
          while (p != NoLink && k < rcap_pkg::ListMax) begin
            nx = slot_next[p];
            step_out.push_back(result_word(rcap_pkg::STAT_OK_NEW, p, 1'b1,
                                           nx == NoLink || k == rcap_pkg::ListMax - 1));
            k++;
            p = nx;
          end
        end
      end
      rcap_pkg::FN_CLEAR: begin
        rebuild_pool();
        step_out.push_back(result_word(rcap_pkg::STAT_OK_NEW, 6'd0, 1'b0, 1'b1));
      end
      default: begin
        step_out.push_back(result_word(rcap_pkg::STAT_NOT_FOUND, 6'd0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  task automatic issue_command(rcap_pkg::in_t w, logic typed, rcap_pkg::out_t want);
    pool_step(w);
    if (typed) begin
      owed.push_back(want);
    end else begin
      foreach (step_out[i]) owed.push_back(step_out[i]);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic set_limit(logic [5:0] v);
    in_valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
  endtask

  // Mostly known addresses and live handles, so that hits, refusals and frees all occur.
  task automatic mixed_traffic(int n);
    rcap_pkg::in_t w;
    logic [5:0]    p;
    int            roll;
    for (int i = 0; i < n; i++) begin
      roll      = $urandom_range(0, 99);
      w.address = ($urandom_range(0, 3) != 0) ? addr_set[$urandom_range(0, 47)] : $urandom;
      w.port    = 16'($urandom);
      if (live_count != 0 && $urandom_range(0, 3) != 0) begin
        p = live_head;
        repeat ($urandom_range(0, live_count - 1)) p = slot_next[p];
        w.handle = p[4:0];
      end else begin
        w.handle = 5'($urandom_range(0, 31));
      end
      if (roll < 35)      w.func = rcap_pkg::FN_ADD;
      else if (roll < 50) w.func = rcap_pkg::FN_FIND;
      else if (roll < 62) w.func = rcap_pkg::FN_REMOVE;
      else if (roll < 85) w.func = rcap_pkg::FN_RELEASE;
      else if (roll < 97) w.func = rcap_pkg::FN_LIST;
      else                w.func = rcap_pkg::FN_CLEAR;
      issue_command(w, 1'b0, '0);
    end
  endtask

  task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : watch
    rcap_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed.size() == 0) begin
        $error("result word arrived with nothing owed");
        failures++;
      end else begin
        want = owed.pop_front();
        match_field("status", 32'(want.status), 32'(out_data.status));
        match_field("entry_index", 32'(want.entry_index), 32'(out_data.entry_index));
        match_field("entry_address", want.entry_address, out_data.entry_address);
        match_field("entry_port", 32'(want.entry_port), 32'(out_data.entry_port));
        match_field("ref_count", 32'(want.ref_count), 32'(out_data.ref_count));
        match_field("active_total", 32'(want.active_total), 32'(out_data.active_total));
        match_field("last", 32'(want.last), 32'(out_data.last));
        if (want.status == rcap_pkg::STAT_FULL) full_seen++;
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rcap_pkg::in_t w;
    logic [5:0]    third_limit;
    logic [31:0]   rep_addr;
    rebuild_pool();
    limit_reg = rcap_pkg::LimitReset;
    foreach (addr_set[i]) addr_set[i] = $urandom;
    plan = '{
      '{1'b0, 6'd0, rcap_pkg::FN_LIST, 32'h0, 16'h0, 5'd0, 1'b1,
        '{rcap_pkg::STAT_NOT_FOUND, 5'd0, 32'h0, 16'h0, 16'h0, 6'd0, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_FIND, 32'h0, 16'h0, 5'd0, 1'b1,
        '{rcap_pkg::STAT_NOT_FOUND, 5'd0, 32'h0, 16'h0, 16'h0, 6'd0, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_REMOVE, 32'h0, 16'h0, 5'd31, 1'b1,
        '{rcap_pkg::STAT_NOT_FOUND, 5'd0, 32'h0, 16'h0, 16'h0, 6'd0, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_RELEASE, 32'h0, 16'h0, 5'd0, 1'b1,
        '{rcap_pkg::STAT_NOT_FOUND, 5'd0, 32'h0, 16'h0, 16'h0, 6'd0, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_ADD, 32'h0, 16'h0, 5'd0, 1'b1,
        '{rcap_pkg::STAT_OK_NEW, 5'd0, 32'h0, 16'h0, 16'h1, 6'd1, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_ADD, 32'hFFFF_FFFF, 16'hFFFF, 5'd0, 1'b1,
        '{rcap_pkg::STAT_OK_NEW, 5'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'h1, 6'd2, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_ADD, 32'hFFFF_FFFF, 16'h1234, 5'd0, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_FIND, 32'h0, 16'h0, 5'd0, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_LIST, 32'h0, 16'h0, 5'd0, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_RELEASE, 32'h0, 16'h0, 5'd1, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_RELEASE, 32'h0, 16'h0, 5'd1, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_REMOVE, 32'h0, 16'h0, 5'd0, 1'b1,
        '{rcap_pkg::STAT_NOT_FOUND, 5'd0, 32'h0, 16'h0, 16'h0, 6'd0, 1'b1}},
      '{1'b1, 6'd1, rcap_pkg::FN_ADD, 32'h0, 16'h0, 5'd0, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_ADD, 32'h0A00_0001, 16'd80, 5'd0, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_ADD, 32'hC0A8_0001, 16'd443, 5'd0, 1'b1,
        '{rcap_pkg::STAT_FULL, 5'd0, 32'h0, 16'h0, 16'h0, 6'd1, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_ADD, 32'h0A00_0001, 16'd8080, 5'd0, 1'b0, '0},
      '{1'b0, 6'd0, rcap_pkg::FN_FIND, 32'hC0A8_0001, 16'h0, 5'd0, 1'b1,
        '{rcap_pkg::STAT_NOT_FOUND, 5'd0, 32'h0, 16'h0, 16'h0, 6'd1, 1'b1}},
      '{1'b0, 6'd0, rcap_pkg::FN_CLEAR, 32'h0, 16'h0, 5'd0, 1'b1,
        '{rcap_pkg::STAT_OK_NEW, 5'd0, 32'h0, 16'h0, 16'h0, 6'd0, 1'b1}},
      '{1'b1, 6'd32, rcap_pkg::FN_ADD, 32'h0, 16'h0, 5'd0, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        set_limit(plan[i].limit);
      end else begin
        w = '{func: plan[i].op, address: plan[i].addr, port: plan[i].port,
              handle: plan[i].handle};
        issue_command(w, plan[i].typed, plan[i].want);
      end
    end

    // Fill the pool to the last slot, try one more, then read the whole chain back.
    for (int i = 0; i <= Pool; i++) begin
      w = '{func: rcap_pkg::FN_ADD, address: addr_set[i], port: 16'($urandom),
            handle: 5'd0};
      issue_command(w, 1'b0, '0);
    end
    w = '{func: rcap_pkg::FN_LIST, address: 32'h0, port: 16'h0, handle: 5'd0};
    issue_command(w, 1'b0, '0);
    mixed_traffic(MixCount);

    set_limit(6'd5);
    send_idle_pct  = 77;
    recv_stall_pct = 12;
    mixed_traffic(MixCount);

    third_limit = 6'($urandom_range(1, 32));
    set_limit(third_limit);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mixed_traffic(MixCount);

    w = '{func: rcap_pkg::FN_CLEAR, address: 32'h0, port: 16'h0, handle: 5'd0};
    issue_command(w, 1'b0, '0);
    rep_addr = $urandom;
    for (int i = 0; i < RepAdds; i++) begin
      w = '{func: rcap_pkg::FN_ADD, address: rep_addr, port: 16'($urandom), handle: 5'd0};
      issue_command(w, 1'b0, '0);
    end
    w = '{func: rcap_pkg::FN_RELEASE, address: 32'h0, port: 16'h0, handle: 5'd0};
    issue_command(w, 1'b0, '0);
    w = '{func: rcap_pkg::FN_LIST, address: 32'h0, port: 16'h0, handle: 5'd0};
    issue_command(w, 1'b0, '0);
    in_valid <= 1'b0;

    while (owed.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d command words and %0d result words, %0d of them refusals.",
             words_sent, words_checked, full_seen);
    $display("Limits 1, 5, 32 and %0d, a filled pool, full lists and repeated adds.",
             third_limit);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
